// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// clocked assertion that a condition never holds
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

// ===== rtl/core/sha1md_pkg.sv =====
// types, constants and helper functions of the sha-1 digest core
package sha1md_pkg;

  // initial vector of the chaining value, word 4 written first
  localparam logic [4:0][31:0] InitVector = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // round constants
  localparam logic [31:0] RoundK0 = 32'h5A827999;
  localparam logic [31:0] RoundK1 = 32'h6ED9EBA1;
  localparam logic [31:0] RoundK2 = 32'h8F1BBCDC;
  localparam logic [31:0] RoundK3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte     = 8'h80;
  localparam logic [5:0] LenFieldPos = 6'd56;
  localparam logic [6:0] LastRound   = 7'd80;
  localparam logic [2:0] LastWordIdx = 3'd4;

  // what a compression pass reads as its message block
  typedef enum logic [1:0] {
    KIND_BODY,   // full block straight from the buffer
    KIND_LAST,   // tail bytes, pad byte, zeros and the bit length
    KIND_PAD_A,  // tail bytes, pad byte and zeros, length follows in another block
    KIND_LEN     // zeros and the bit length
  } blk_kind_e;

  // control state of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_PAD2,
    ST_DRAIN,
    ST_OUT
  } fsm_e;

  typedef logic [4:0][31:0] hash_t;

  // command that starts one compression pass
  typedef struct packed {
    logic        start;
    blk_kind_e   kind;
    logic [5:0]  tail;
    logic [60:0] count;
  } eng_cmd_t;

  // one byte write into the block buffer
  typedef struct packed {
    logic       en;
    logic [3:0] addr;
    logic [1:0] lane;
    logic [7:0] data;
  } buf_wr_t;

  // block word as seen by the rounds, with padding and length filled in
  function automatic logic [31:0] fill_word(blk_kind_e kind, logic [5:0] tail,
                                            logic [60:0] cnt, logic [3:0] idx,
                                            logic [31:0] mem);
    logic [31:0] w;
    logic [63:0] bitlen;
    logic [5:0]  pos;
    w      = mem;
    bitlen = {cnt, 3'b000};
    if (kind != KIND_BODY) begin
      for (int k = 0; k < 4; k++) begin
        pos = {idx, 2'(k)};
        if (kind == KIND_LEN || pos > tail) begin
          w[31 - 8 * k -: 8] = 8'h00;
        end else if (pos == tail) begin
          w[31 - 8 * k -: 8] = PadByte;
        end
      end
      if (kind != KIND_PAD_A) begin
        if (idx == 4'd14) begin
          w = bitlen[63:32];
        end else if (idx == 4'd15) begin
          w = bitlen[31:0];
        end
      end
    end
    return w;
  endfunction

  // boolean function of the round group
  function automatic logic [31:0] round_fn(logic [6:0] rnd, logic [31:0] b,
                                           logic [31:0] c, logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  // additive constant of the round group
  function automatic logic [31:0] round_k(logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) begin
      k = RoundK0;
    end else if (rnd < 7'd40) begin
      k = RoundK1;
    end else if (rnd < 7'd60) begin
      k = RoundK2;
    end else begin
      k = RoundK3;
    end
    return k;
  endfunction

endpackage

// ===== rtl/core/sha1md_buf.sv =====
// block buffer: 16 words with byte writes and a registered read port
module sha1md_buf (
  input  logic                  clk_i,
  input  sha1md_pkg::buf_wr_t   wr_i,
  input  logic [3:0]            rd_addr_i,
  output logic [31:0]           rd_data_o
);

  logic [3:0][7:0] mem_q [16];
  logic [31:0]     rd_data_q;

  // byte write, lane 0 is the most significant byte of the word
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr][2'd3 - wr_i.lane] <= wr_i.data;
    end
  end

  // synchronous read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/sha1md_rounds.sv =====
// round engine: 80 rounds over one block, then the chaining add
module sha1md_rounds (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha1md_pkg::eng_cmd_t  cmd_i,
  input  logic                  cv_init_i,
  output logic [3:0]            rd_addr_o,
  input  logic [31:0]           rd_data_i,
  output logic                  busy_o,
  output sha1md_pkg::hash_t     cv_o
);

  logic                  busy_q;
  logic [6:0]            rnd_q;
  sha1md_pkg::hash_t     cv_q;
  sha1md_pkg::hash_t     work_q;
  logic [15:0][31:0]     sched_q;
  sha1md_pkg::blk_kind_e kind_q;
  logic [5:0]            tail_q;
  logic [60:0]           count_q;

  logic [31:0] mix;
  logic [31:0] wt;
  logic [31:0] tmp;
  logic [3:0]  rnd_nx;

  // word r of the block is addressed in the cycle before round r
  assign rnd_nx    = rnd_q[3:0] + 4'd1;
  assign rd_addr_o = cmd_i.start ? 4'd0 : rnd_nx;

  // schedule word and round sum
  always_comb begin
    mix = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
    if (rnd_q < 7'd16) begin
      wt = sha1md_pkg::fill_word(kind_q, tail_q, count_q, rnd_q[3:0], rd_data_i);
    end else begin
      wt = {mix[30:0], mix[31]};
    end
    tmp = {work_q[0][26:0], work_q[0][31:27]}
        + sha1md_pkg::round_fn(rnd_q, work_q[1], work_q[2], work_q[3])
        + work_q[4] + sha1md_pkg::round_k(rnd_q) + wt;
  end

  // control and chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= '0;
      cv_q   <= sha1md_pkg::InitVector;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      rnd_q  <= '0;
    end else if (busy_q) begin
      if (rnd_q == sha1md_pkg::LastRound) begin
        busy_q <= 1'b0;
        for (int i = 0; i < 5; i++) begin
          cv_q[i] <= cv_q[i] + work_q[i];
        end
      end else begin
        rnd_q <= rnd_q + 7'd1;
      end
    end else if (cv_init_i) begin
      cv_q <= sha1md_pkg::InitVector;
    end
  end

  // working variables, schedule line and pass settings
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      work_q  <= cv_q;
      kind_q  <= cmd_i.kind;
      tail_q  <= cmd_i.tail;
      count_q <= cmd_i.count;
    end else if (busy_q && rnd_q != sha1md_pkg::LastRound) begin
      work_q[0] <= tmp;
      work_q[1] <= work_q[0];
      work_q[2] <= {work_q[1][1:0], work_q[1][31:2]};
      work_q[3] <= work_q[2];
      work_q[4] <= work_q[3];
      sched_q   <= {wt, sched_q[15:1]};
    end
  end

  assign busy_o = busy_q;
  assign cv_o   = cv_q;

endmodule

// ===== rtl/core/sha1_message_digest_core.sv =====
// SHA-1 digest core: byte stream in, five digest words out per message.
// A byte is taken every cycle while bytes are collected. Each 64-byte block
// then occupies the round engine for 80 rounds and one chaining add; the
// byte that fills a block waits while the engine still works on the
// previous block and is taken in the cycle after the chaining add. The last
// item starts a padding pass, or two when the tail leaves no room for the
// bit length, and then the five digest words follow, one per cycle while
// the output side takes them.
// No input is taken from the last item until the fifth digest word has been taken.
module sha1_message_digest_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        digest_last_o
);

  sha1md_pkg::fsm_e     state_q, state_d;
  logic [60:0]          count_q;
  logic [60:0]          count_nx;
  logic [5:0]           tail_q;
  logic [60:0]          len_q;
  logic [2:0]           idx_q;
  logic                 in_acc;
  logic                 out_acc;
  logic                 busy;
  logic                 cv_init;
  logic [3:0]           rd_addr;
  logic [31:0]          rd_data;
  sha1md_pkg::hash_t    cv;
  sha1md_pkg::eng_cmd_t cmd;
  sha1md_pkg::buf_wr_t  wr;

  // handshakes
  assign in_stall_o = (state_q != sha1md_pkg::ST_IDLE) || (busy && (&count_q[5:0]));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign count_nx   = byte_valid_i ? count_q + 61'd1 : count_q;

  // byte write into the block buffer
  assign wr.en   = in_acc && byte_valid_i;
  assign wr.addr = count_q[5:2];
  assign wr.lane = count_q[1:0];
  assign wr.data = data_byte_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sha1md_pkg::ST_IDLE: begin
        if (in_acc && end_of_message_i) begin
          state_d = sha1md_pkg::ST_PAD;
        end
      end
      sha1md_pkg::ST_PAD: begin
        if (!busy) begin
          state_d = (tail_q >= sha1md_pkg::LenFieldPos) ? sha1md_pkg::ST_PAD2
                                                          : sha1md_pkg::ST_DRAIN;
        end
      end
      sha1md_pkg::ST_PAD2: begin
        if (!busy) begin
          state_d = sha1md_pkg::ST_DRAIN;
        end
      end
      sha1md_pkg::ST_DRAIN: begin
        if (!busy) begin
          state_d = sha1md_pkg::ST_OUT;
        end
      end
      sha1md_pkg::ST_OUT: begin
        if (out_acc && idx_q == sha1md_pkg::LastWordIdx) begin
          state_d = sha1md_pkg::ST_IDLE;
        end
      end
      default: state_d = sha1md_pkg::ST_IDLE;
    endcase
  end

  // engine commands and output valid
  always_comb begin
    cmd.start   = 1'b0;
    cmd.kind    = sha1md_pkg::KIND_BODY;
    cmd.tail    = tail_q;
    cmd.count   = len_q;
    out_valid_o = 1'b0;
    unique case (state_q)
      sha1md_pkg::ST_IDLE: begin
        cmd.start = in_acc && byte_valid_i && (&count_q[5:0]);
      end
      sha1md_pkg::ST_PAD: begin
        cmd.start = !busy;
        cmd.kind  = (tail_q >= sha1md_pkg::LenFieldPos) ? sha1md_pkg::KIND_PAD_A
                                                         : sha1md_pkg::KIND_LAST;
      end
      sha1md_pkg::ST_PAD2: begin
        cmd.start = !busy;
        cmd.kind  = sha1md_pkg::KIND_LEN;
      end
      sha1md_pkg::ST_DRAIN: begin
        cmd.start = 1'b0;
      end
      sha1md_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        cmd.start = 1'b0;
      end
    endcase
  end

  assign cv_init = out_acc && idx_q == sha1md_pkg::LastWordIdx;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1md_pkg::ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        count_q <= end_of_message_i ? '0 : count_nx;
      end
      if (state_q != sha1md_pkg::ST_OUT) begin
        idx_q <= '0;
      end else if (out_acc) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  // tail position and length of the ending message
  always_ff @(posedge clk_i) begin
    if (in_acc && end_of_message_i) begin
      tail_q <= count_nx[5:0];
      len_q  <= count_nx;
    end
  end

  sha1md_buf u_buf (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  sha1md_rounds u_rounds (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .cv_init_i (cv_init),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .busy_o    (busy),
    .cv_o      (cv)
  );

  // digest word output
  assign digest_word_o = cv[idx_q];
  assign word_index_o  = idx_q;
  assign digest_last_o = (idx_q == sha1md_pkg::LastWordIdx);

endmodule

// ===== rtl/core/sha1md_checker.sv =====
// port checker of the sha-1 digest core and its bind
`include "assert_macros.svh"

module sha1md_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  data_byte_i,
  input logic        byte_valid_i,
  input logic        end_of_message_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        digest_last_o
);

  // a stalled digest word holds
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(digest_word_o) && $stable(word_index_o))

  // the last flag marks exactly word four
  `ASSERT_CLK(a_last_flag, clk_i, rst_ni, out_valid_o |-> (digest_last_o == (word_index_o == 3'd4)))

  // digest words follow one another without a gap in the index
  `ASSERT_CLK(a_index_step, clk_i, rst_ni, out_valid_o && !out_stall_i && !digest_last_o |=> out_valid_o && word_index_o == $past(word_index_o) + 3'd1)

  // no word is taken in while a digest is going out
  `ASSERT_NEVER(a_no_input_on_out, clk_i, rst_ni, out_valid_o && !in_stall_o)

endmodule

bind sha1_message_digest_core sha1md_checker u_checker (.*);

// ===== dv/testbench.sv =====
// self-checking testbench of the sha-1 digest core
module testbench;

  // sha-1 initial vector and round constants
  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hC3D2E1F0;
  localparam logic [31:0] Kc0 = 32'h5A827999;
  localparam logic [31:0] Kc1 = 32'h6ED9EBA1;
  localparam logic [31:0] Kc2 = 32'h8F1BBCDC;
  localparam logic [31:0] Kc3 = 32'hCA62C1D6;
  localparam logic [7:0]  MarkerByte = 8'h80;
  localparam logic [2:0]  FinalWordIdx = 3'd4;
  localparam int          RandomWords = 180;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        byte_valid_i = 1'b0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        digest_last_o;

  sha1_message_digest_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .byte_valid_i     (byte_valid_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .digest_word_o    (digest_word_o),
    .word_index_o     (word_index_o),
    .digest_last_o    (digest_last_o)
  );

  // one expected digest word
  typedef struct packed {
    logic [31:0] dword;
    logic [2:0]  idx;
    logic        last;
  } digest_exp_t;

  // one directed stimulus row, digest filled in where it is well known
  typedef struct packed {
    logic [7:0]   data;
    logic         has_byte;
    logic         eom;
    logic         known;
    logic [159:0] digest;
  } stim_row_t;

  stim_row_t directed_rows [13] = '{
    // empty message
    '{8'h00, 1'b0, 1'b1, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709},
    // "abc" with an ignored word in the middle
    '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'hC3, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, 160'ha9993e364706816aba3e25717850c26c9cd0d89d},
    // byte extremes, closed by a last word that carries no byte
    '{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h5A, 1'b0, 1'b1, 1'b0, 160'h0},
    // single byte messages, then a two-byte message with an ignored word
    '{8'hFF, 1'b1, 1'b1, 1'b0, 160'h0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h7F, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'h01, 1'b1, 1'b1, 1'b0, 160'h0}
  };

  // predictor state
  logic [31:0] chain_val [5];
  logic [7:0]  blk_bytes [64];
  logic [60:0] msg_bytes;
  logic [31:0] pred_digest [5];

  digest_exp_t digest_q [$];
  int unsigned error_count = 0;
  int unsigned words_checked = 0;
  int unsigned msgs_hashed = 0;
  int unsigned longest_msg = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int unsigned rx_hold = 0;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // 80-round compression of the block buffer into the chaining value
  function automatic void sha1_compress();
    logic [31:0] sched [16];
    logic [31:0] a, b, c, d, e, f, k, t, w;
    for (int j = 0; j < 16; j++) begin
      sched[j] = {blk_bytes[4*j], blk_bytes[4*j+1], blk_bytes[4*j+2], blk_bytes[4*j+3]};
    end
    a = chain_val[0];
    b = chain_val[1];
    c = chain_val[2];
    d = chain_val[3];
    e = chain_val[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        w = sched[r];
      end else begin
        w = sched[(r + 13) & 15] ^ sched[(r + 8) & 15] ^ sched[(r + 2) & 15] ^ sched[r & 15];
        w = {w[30:0], w[31]};
        sched[r & 15] = w;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = Kc0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = Kc1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = Kc2;
      end else begin
        f = b ^ c ^ d;
        k = Kc3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_val[0] += a;
    chain_val[1] += b;
    chain_val[2] += c;
    chain_val[3] += d;
    chain_val[4] += e;
  endfunction

  // back to the initial vector and an empty message
  function automatic void restart_message();
    chain_val[0] = Iv0;
    chain_val[1] = Iv1;
    chain_val[2] = Iv2;
    chain_val[3] = Iv3;
    chain_val[4] = Iv4;
    msg_bytes = '0;
  endfunction

  // take one input word; returns 1 when it closes a message and fills pred_digest
  function automatic bit absorb_word(logic [7:0] data, logic has_byte, logic eom);
    int unsigned pos;
    logic [63:0] bit_len;
    if (has_byte) begin
      pos = msg_bytes[5:0];
      blk_bytes[pos] = data;
      msg_bytes = msg_bytes + 61'd1;
      if (pos == 63) sha1_compress();
    end
    if (!eom) return 1'b0;
    // pad byte, zeros, then the bit length, spilling into a second block if needed
    pos = msg_bytes[5:0];
    bit_len = {msg_bytes, 3'b000};
    blk_bytes[pos] = MarkerByte;
    for (int j = pos + 1; j < 64; j++) blk_bytes[j] = 8'h00;
    if (pos >= 56) begin
      sha1_compress();
      for (int j = 0; j < 56; j++) blk_bytes[j] = 8'h00;
    end
    for (int j = 0; j < 8; j++) blk_bytes[63 - j] = bit_len[8*j +: 8];
    sha1_compress();
    for (int j = 0; j < 5; j++) pred_digest[j] = chain_val[j];
    restart_message();
    return 1'b1;
  endfunction

  // offer one word after a random gap and hold it until it is taken
  task automatic offer_word(input logic [7:0] data, input logic has_byte, input logic eom,
                            input logic known, input logic [159:0] known_digest);
    int unsigned gap;
    digest_exp_t exp_word;
    if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    data_byte_i      <= data;
    byte_valid_i     <= has_byte;
    end_of_message_i <= eom;
    // the word stays offered until taken, so its digest can be queued right away
    if (absorb_word(data, has_byte, eom)) begin
      for (int j = 0; j < 5; j++) begin
        exp_word.dword = known ? known_digest[159 - 32*j -: 32] : pred_digest[j];
        exp_word.idx   = 3'(j);
        exp_word.last  = (3'(j) == FinalWordIdx);
        digest_q.push_back(exp_word);
      end
      msgs_hashed++;
    end
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    int unsigned rand_words;
    int unsigned rand_msgs;
    int unsigned len;
    bit          open_end;
    rand_words = 0;
    rand_msgs = 0;
    for (int j = 0; j < 64; j++) blk_bytes[j] = 8'h00;
    restart_message();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      offer_word(directed_rows[i].data, directed_rows[i].has_byte, directed_rows[i].eom,
                 directed_rows[i].known, directed_rows[i].digest);
    end

    // random messages: block boundary lengths first, then mostly short ones
    while (rand_words < RandomWords) begin
      if (rand_msgs == 0) begin
        len = 56;
      end else if (rand_msgs == 1) begin
        len = 64;
      end else begin
        case ($urandom_range(0, 9))
          7: len = $urandom_range(55, 57);
          8: len = $urandom_range(63, 65);
          9: len = $urandom_range(9, 30);
          default: len = $urandom_range(0, 8);
        endcase
      end
      open_end = (len == 0) || ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        // ignored word mixed into the stream now and then
        if ($urandom_range(0, 9) == 0) begin
          offer_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 160'h0);
        end
        offer_word(8'($urandom_range(0, 255)), 1'b1, (k == len - 1) && !open_end,
                   1'b0, 160'h0);
      end
      if (open_end) offer_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 160'h0);
      if (len > longest_msg) longest_msg = len;
      rand_words += len + (open_end ? 1 : 0);
      rand_msgs++;
    end
    in_valid_i <= 1'b0;

    // drain and let any stray output show up
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("testbench: %0d messages hashed (%0d random, longest %0d bytes)",
             msgs_hashed, rand_msgs, longest_msg);
    $display("testbench: %0d digest words checked, %0d mismatches",
             words_checked, error_count);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // output side: random stalls and digest word checking
  always @(posedge clk_i) begin
    digest_exp_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        words_checked++;
        if (digest_q.size() == 0) begin
          $error("digest word %08h arrived with no digest pending", digest_word_o);
          error_count++;
        end else begin
          want = digest_q.pop_front();
          if (digest_word_o !== want.dword) begin
            $error("digest_word: expected %08h, got %08h", want.dword, digest_word_o);
            error_count++;
          end
          if (word_index_o !== want.idx) begin
            $error("word_index: expected %0d, got %0d", want.idx, word_index_o);
            error_count++;
          end
          if (digest_last_o !== want.last) begin
            $error("digest_last: expected %0b, got %0b", want.last, digest_last_o);
            error_count++;
          end
        end
        if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
        rx_hold = rx_burst ? 0 : $urandom_range(0, 7);
      end else if (rx_hold != 0) begin
        rx_hold--;
      end
      out_stall_i <= (rx_hold != 0);
    end
  end

  // watchdog
  initial begin
    #5000000;
    $error("run did not finish in time, %0d digest words still pending", digest_q.size());
    $display("testbench: FAIL");
    $finish;
  end

endmodule
